// File: hdl/scvc_pkg.sv
package scvc_pkg;

	localparam int unsigned NUM_DETECTORS = 6;
	localparam int unsigned DET_W         = 3;
	localparam int unsigned CNT_W         = 17;
	localparam int unsigned TOTAL_W       = 32;
	localparam int unsigned FLOW_W        = 10;
	localparam int unsigned TICKS_W       = 16;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 32;

	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_BAND_ONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TWO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_THREE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_IVL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLD = 3'd5;

	localparam logic [TOTAL_W-1:0] RST_BAND_ONE   = 32'd1000;
	localparam logic [TOTAL_W-1:0] RST_BAND_TWO   = 32'd2000;
	localparam logic [TOTAL_W-1:0] RST_BAND_THREE = 32'd3000;
	localparam logic [TOTAL_W-1:0] RST_LIMIT      = 32'd4000;
	localparam logic [TICKS_W-1:0] RST_POLL_IVL   = 16'd100;
	localparam logic [TICKS_W-1:0] RST_ALARM_HOLD = 16'd3000;

	// detector rotation
	localparam logic [DET_W-1:0] DET_BUTTON  = 3'd0;
	localparam logic [DET_W-1:0] DET_BAND1   = 3'd1;
	localparam logic [DET_W-1:0] DET_BAND2   = 3'd2;
	localparam logic [DET_W-1:0] DET_BAND3   = 3'd3;
	localparam logic [DET_W-1:0] DET_LIMIT   = 3'd4;
	localparam logic [DET_W-1:0] DET_TIMEOUT = 3'd5;
	localparam logic [DET_W-1:0] DET_LAST    = DET_W'(NUM_DETECTORS - 1);

	// external mode codes
	localparam logic [2:0] MC_IDLE     = 3'd0;
	localparam logic [2:0] MC_OPEN     = 3'd1;
	localparam logic [2:0] MC_ALARM1   = 3'd2;
	localparam logic [2:0] MC_ALARM2   = 3'd3;
	localparam logic [2:0] MC_ALARM3   = 3'd4;
	localparam logic [2:0] MC_LIMIT    = 3'd5;
	localparam logic [2:0] MC_FINISHED = 3'd6;

	localparam logic [2:0] BUZZ_OFF    = 3'd0;
	localparam logic [2:0] BUZZ_BAND1  = 3'd1;
	localparam logic [2:0] BUZZ_BAND2  = 3'd2;
	localparam logic [2:0] BUZZ_BAND3  = 3'd3;
	localparam logic [2:0] BUZZ_LIMIT  = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_BUTTON  = 3'd1,
		EV_BAND1   = 3'd2,
		EV_BAND2   = 3'd3,
		EV_BAND3   = 3'd4,
		EV_LIMIT   = 3'd5,
		EV_TIMEOUT = 3'd6,
		EV_CLOSE   = 3'd7
	} evt_code_t;

	typedef enum logic [6:0] {
		MODE_IDLE     = 7'b0000001,
		MODE_OPEN     = 7'b0000010,
		MODE_ALARM1   = 7'b0000100,
		MODE_ALARM2   = 7'b0001000,
		MODE_ALARM3   = 7'b0010000,
		MODE_LIMIT    = 7'b0100000,
		MODE_FINISHED = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] band_one;
		logic [TOTAL_W-1:0] band_two;
		logic [TOTAL_W-1:0] band_three;
		logic [TOTAL_W-1:0] limit;
		logic [TICKS_W-1:0] poll_ivl;
		logic [TICKS_W-1:0] alarm_hold;
	} cfg_t;

	typedef struct packed {
		evt_code_t  evt;
		logic [3:0] used;
	} det_res_t;

	typedef struct packed {
		mode_t      mode;
		logic       valve;
		logic [2:0] buzzer;
		logic       restart_alarm;
		logic       clear_total;
	} fsm_res_t;

	function automatic logic [2:0] mode_code(mode_t m);
		logic [2:0] c;
		c = MC_IDLE;
		case (m)
			MODE_OPEN:     c = MC_OPEN;
			MODE_ALARM1:   c = MC_ALARM1;
			MODE_ALARM2:   c = MC_ALARM2;
			MODE_ALARM3:   c = MC_ALARM3;
			MODE_LIMIT:    c = MC_LIMIT;
			MODE_FINISHED: c = MC_FINISHED;
			default:       c = MC_IDLE;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/scvc_detect.sv
module scvc_detect (
	input  logic [scvc_pkg::DET_W-1:0]   poll_index,
	input  logic                         push,
	input  scvc_pkg::mode_t              mode,
	input  logic [scvc_pkg::TOTAL_W-1:0] total,
	input  logic [3:0]                   used,
	input  logic [scvc_pkg::CNT_W-1:0]   since_alarm,
	input  scvc_pkg::cfg_t               cfg,
	output scvc_pkg::det_res_t           res
);
	import scvc_pkg::*;

	logic ge1, ge2, ge3, ge_lim;
	logic up_open, up_alarm1, up_alarm2, up_alarm3, in_alarm;

	assign ge1    = total >= cfg.band_one;
	assign ge2    = total >= cfg.band_two;
	assign ge3    = total >= cfg.band_three;
	assign ge_lim = total >= cfg.limit;

	assign up_open   = (mode == MODE_IDLE) || (mode == MODE_OPEN);
	assign up_alarm1 = up_open || (mode == MODE_ALARM1);
	assign up_alarm2 = up_alarm1 || (mode == MODE_ALARM2);
	assign up_alarm3 = up_alarm2 || (mode == MODE_ALARM3);
	assign in_alarm  = (mode == MODE_ALARM1) || (mode == MODE_ALARM2) ||
	                   (mode == MODE_ALARM3) || (mode == MODE_LIMIT);

	// a band that fires marks itself and every lower band as spent
	always_comb begin
		res.evt  = EV_NONE;
		res.used = used;
		unique case (poll_index)
			DET_BUTTON: begin
				if (push) res.evt = EV_BUTTON;
			end
			DET_BAND1: begin
				if (up_open && !used[0] && ge1 && !ge2) begin
					res.evt  = EV_BAND1;
					res.used = used | 4'b0001;
				end
			end
			DET_BAND2: begin
				if (up_alarm1 && !used[1] && ge2 && !ge3) begin
					res.evt  = EV_BAND2;
					res.used = used | 4'b0011;
				end
			end
			DET_BAND3: begin
				if (up_alarm2 && !used[2] && ge3 && !ge_lim) begin
					res.evt  = EV_BAND3;
					res.used = used | 4'b0111;
				end
			end
			DET_LIMIT: begin
				if (up_alarm3 && !used[3] && ge_lim) begin
					res.evt  = EV_LIMIT;
					res.used = 4'b1111;
				end
			end
			DET_TIMEOUT: begin
				if (in_alarm && (since_alarm > {1'b0, cfg.alarm_hold})) res.evt = EV_TIMEOUT;
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/scvc_fsm.sv
module scvc_fsm (
	input  scvc_pkg::mode_t     mode,
	input  logic                valve,
	input  logic [2:0]          buzzer,
	input  scvc_pkg::evt_code_t evt,
	output scvc_pkg::fsm_res_t  res
);
	import scvc_pkg::*;

	always_comb begin
		res.mode          = mode;
		res.valve         = valve;
		res.buzzer        = buzzer;
		res.restart_alarm = 1'b0;
		res.clear_total   = 1'b0;
		unique case (mode)
			MODE_IDLE: begin
				if (evt == EV_BUTTON) begin
					res.valve = 1'b1;
					res.mode  = MODE_OPEN;
				end
			end
			MODE_OPEN: begin
				if (evt == EV_BUTTON || evt == EV_CLOSE) begin
					res.valve = 1'b0;
					res.mode  = MODE_IDLE;
				end else if (evt == EV_BAND1) begin
					res.mode = MODE_ALARM1; res.buzzer = BUZZ_BAND1; res.restart_alarm = 1'b1;
				end else if (evt == EV_BAND2) begin
					res.mode = MODE_ALARM2; res.buzzer = BUZZ_BAND2; res.restart_alarm = 1'b1;
				end else if (evt == EV_BAND3) begin
					res.mode = MODE_ALARM3; res.buzzer = BUZZ_BAND3; res.restart_alarm = 1'b1;
				end else if (evt == EV_LIMIT) begin
					res.mode = MODE_LIMIT; res.buzzer = BUZZ_LIMIT; res.restart_alarm = 1'b1;
				end
			end
			MODE_ALARM1, MODE_ALARM2, MODE_ALARM3: begin
				// escalation keeps the alarm timer running
				if (evt == EV_TIMEOUT) begin
					res.buzzer = BUZZ_OFF;
					res.mode   = MODE_OPEN;
				end else if (evt == EV_CLOSE) begin
					res.valve = 1'b0;
					res.mode  = MODE_IDLE;
				end else if (mode == MODE_ALARM1 && evt == EV_BAND2) begin
					res.mode = MODE_ALARM2; res.buzzer = BUZZ_BAND2;
				end else if (mode == MODE_ALARM2 && evt == EV_BAND3) begin
					res.mode = MODE_ALARM3; res.buzzer = BUZZ_BAND3;
				end else if (mode == MODE_ALARM3 && evt == EV_LIMIT) begin
					res.mode = MODE_LIMIT; res.buzzer = BUZZ_LIMIT;
				end
			end
			MODE_LIMIT: begin
				if (evt == EV_TIMEOUT) begin
					res.buzzer = BUZZ_OFF;
					res.valve  = 1'b0;
					res.mode   = MODE_FINISHED;
				end
			end
			MODE_FINISHED: begin
				if (evt == EV_BUTTON) begin
					res.clear_total = 1'b1;
					res.mode        = MODE_IDLE;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/staged_consumption_valve_controller.sv
// channel | signals                                                   | beat when
// --------+-----------------------------------------------------------+-----------------------
// tick in | in_valid in_stall button_push flow_ml close_request       | in_valid && !in_stall
// result  | out_valid out_stall event_code mode valve_on buzzer_level | out_valid && !out_stall
//         | total_out_ml                                              |
// config  | cfg_we cfg_index cfg_data                                 | cfg_we
//
// One tick per clock while out_stall does not hold the result; the beat loads the
// input register, then the state update loads the result register.
// The per-tick path is the saturating total add feeding the band compares.
// arst_n clears the mode machine, counters, flags and both valid bits and loads
// the register defaults. A stalled result holds the state update; the input
// register still takes one more beat if it is empty, then in_stall rises.
module staged_consumption_valve_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            button_push,
	input  logic [scvc_pkg::FLOW_W-1:0]     flow_ml,
	input  logic                            close_request,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      event_code,
	output logic [2:0]                      mode,
	output logic                            valve_on,
	output logic [2:0]                      buzzer_level,
	output logic [scvc_pkg::TOTAL_W-1:0]    total_out_ml,
	input  logic                            cfg_we,
	input  logic [scvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scvc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scvc_pkg::*;

	// config registers
	cfg_t cfg_q;

	// input stage
	logic              valid_s1;
	logic              push_s1;
	logic [FLOW_W-1:0] flow_s1;
	logic              close_s1;

	// tick state
	mode_t              mode_q;
	logic [TOTAL_W-1:0] total_q;
	logic [3:0]         used_q;
	logic [DET_W-1:0]   poll_idx_q;
	logic [CNT_W-1:0]   since_poll_q;
	logic [CNT_W-1:0]   since_alarm_q;
	logic               valve_q;
	logic [2:0]         buzzer_q;

	logic out_valid_q;
	logic advance;

	logic [CNT_W-1:0]   sp_inc, sa_inc;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_new;
	logic               poll_due;
	det_res_t           det;
	evt_code_t          evt;
	logic [3:0]         used_new;
	fsm_res_t           nxt;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_one   <= RST_BAND_ONE;
			cfg_q.band_two   <= RST_BAND_TWO;
			cfg_q.band_three <= RST_BAND_THREE;
			cfg_q.limit      <= RST_LIMIT;
			cfg_q.poll_ivl   <= RST_POLL_IVL;
			cfg_q.alarm_hold <= RST_ALARM_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_ONE:   cfg_q.band_one   <= cfg_data;
				REG_BAND_TWO:   cfg_q.band_two   <= cfg_data;
				REG_BAND_THREE: cfg_q.band_three <= cfg_data;
				REG_LIMIT:      cfg_q.limit      <= cfg_data;
				REG_POLL_IVL:   cfg_q.poll_ivl   <= cfg_data[TICKS_W-1:0];
				REG_ALARM_HOLD: cfg_q.alarm_hold <= cfg_data[TICKS_W-1:0];
				default: ;  // out-of-range index: dropped
			endcase
		end
	end

	// input register; loads whenever empty or draining this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			push_s1  <= button_push;
			flow_s1  <= flow_ml;
			close_s1 <= close_request;
		end
	end

	// counters step first, then flow is added
	assign sp_inc    = (since_poll_q == CNT_MAX) ? since_poll_q : since_poll_q + 1'b1;
	assign sa_inc    = (since_alarm_q == CNT_MAX) ? since_alarm_q : since_alarm_q + 1'b1;
	assign sum       = {1'b0, total_q} + {{(TOTAL_W + 1 - FLOW_W){1'b0}}, flow_s1};
	assign total_new = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	// a close request takes the tick; the poll slot is skipped, not consumed
	assign poll_due = !close_s1 && (sp_inc > {1'b0, cfg_q.poll_ivl});

	scvc_detect u_detect (
		.poll_index  (poll_idx_q),
		.push        (push_s1),
		.mode        (mode_q),
		.total       (total_new),
		.used        (used_q),
		.since_alarm (sa_inc),
		.cfg         (cfg_q),
		.res         (det)
	);

	always_comb begin
		evt      = EV_NONE;
		used_new = used_q;
		if (close_s1) begin
			evt = EV_CLOSE;
		end else if (poll_due) begin
			evt      = det.evt;
			used_new = det.used;
		end
	end

	scvc_fsm u_fsm (
		.mode   (mode_q),
		.valve  (valve_q),
		.buzzer (buzzer_q),
		.evt    (evt),
		.res    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			total_q       <= '0;
			used_q        <= '0;
			poll_idx_q    <= DET_BUTTON;
			since_poll_q  <= '0;
			since_alarm_q <= '0;
			valve_q       <= 1'b0;
			buzzer_q      <= BUZZ_OFF;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				mode_q        <= nxt.mode;
				// finished + button drops the total, this tick's flow included
				total_q       <= nxt.clear_total ? '0 : total_new;
				used_q        <= nxt.clear_total ? 4'b0000 : used_new;
				since_poll_q  <= poll_due ? '0 : sp_inc;
				since_alarm_q <= nxt.restart_alarm ? '0 : sa_inc;
				valve_q       <= nxt.valve;
				buzzer_q      <= nxt.buzzer;
				if (poll_due) begin
					poll_idx_q <= (poll_idx_q == DET_LAST) ? DET_BUTTON : poll_idx_q + 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded together with the state
	always_ff @(posedge clk) begin
		if (advance) begin
			event_code   <= evt;
			mode         <= mode_code(nxt.mode);
			valve_on     <= nxt.valve;
			buzzer_level <= nxt.buzzer;
			total_out_ml <= nxt.clear_total ? '0 : total_new;
		end
	end

endmodule

// File: hdl/scvc_checker.sv
module scvc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [2:0]                   event_code,
	input logic [2:0]                   mode,
	input logic                         valve_on,
	input logic [2:0]                   buzzer_level,
	input logic [scvc_pkg::TOTAL_W-1:0] total_out_ml
);
	import scvc_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(mode) &&
			$stable(valve_on) && $stable(buzzer_level) && $stable(total_out_ml))
		else $error("result changed while stalled");

	// with the result slot empty the input never backs up
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result slot");

	// valve is driven exactly in open, alarm and limit modes
	a_valve: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> valve_on == (mode == MC_OPEN || mode == MC_ALARM1 ||
			mode == MC_ALARM2 || mode == MC_ALARM3 || mode == MC_LIMIT))
		else $error("valve drive disagrees with mode");

	// alarm1 and limit modes carry their own buzzer pattern
	a_buzz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == MC_ALARM1 || mode == MC_LIMIT) |->
			(buzzer_level == ((mode == MC_ALARM1) ? BUZZ_BAND1 : BUZZ_LIMIT)))
		else $error("buzzer pattern disagrees with alarm mode");

	// after a close the mode is idle, limit or finished; in limit the valve stays open
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_CLOSE |->
			(mode == MC_IDLE || mode == MC_LIMIT || mode == MC_FINISHED))
		else $error("close event left an open mode");

endmodule

bind staged_consumption_valve_controller scvc_checker u_scvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_code   (event_code),
	.mode         (mode),
	.valve_on     (valve_on),
	.buzzer_level (buzzer_level),
	.total_out_ml (total_out_ml)
);

// File: tb/sv/tb_staged_consumption_valve_controller.sv
`timescale 1ns / 1ps

module tb_staged_consumption_valve_controller;
	import scvc_pkg::*;

	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 4;        // quiet time after each drain
	localparam int HOLD_CYCLES   = 80;       // long receiver hold-off
	localparam int WATCHDOG_NS   = 2_000_000;

	// indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

	// one tick as offered on the input channel
	typedef struct packed {
		logic              push;
		logic [FLOW_W-1:0] flow;
		logic              close;
	} tick_item_t;

	// one result beat
	typedef struct packed {
		evt_code_t          evt;
		logic [2:0]         mode;
		logic               valve;
		logic [2:0]         buzz;
		logic [TOTAL_W-1:0] total;
	} tick_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  button_push = 1'b0;
	logic [FLOW_W-1:0]     flow_ml = '0;
	logic                  close_request = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            event_code;
	logic [2:0]            mode;
	logic                  valve_on;
	logic [2:0]            buzzer_level;
	logic [TOTAL_W-1:0]    total_out_ml;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	staged_consumption_valve_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_push  (button_push),
		.flow_ml      (flow_ml),
		.close_request(close_request),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.mode         (mode),
		.valve_on     (valve_on),
		.buzzer_level (buzzer_level),
		.total_out_ml (total_out_ml),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow copy of the controller: registers plus per-tick state.
	// ---------------------------------------------------------------
	cfg_t shadow_cfg = {RST_BAND_ONE, RST_BAND_TWO, RST_BAND_THREE, RST_LIMIT,
		RST_POLL_IVL, RST_ALARM_HOLD};

	logic [2:0]         shadow_mode       = MC_IDLE;
	logic [TOTAL_W-1:0] shadow_total      = '0;
	logic [3:0]         shadow_used       = '0;  // bit0 band1 .. bit3 limit
	logic [DET_W-1:0]   shadow_det        = DET_BUTTON;
	logic [CNT_W-1:0]   shadow_since_poll = '0;
	logic [CNT_W-1:0]   shadow_since_alarm = '0;
	logic               shadow_valve      = 1'b0;
	logic [2:0]         shadow_buzz       = BUZZ_OFF;

	tick_item_t   pending_ticks[$];      // ticks waiting for the driver
	tick_result_t predicted_outputs[$];  // results owed by the block

	tick_item_t offered;                 // payload currently on the input port
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int fail_count    = 0;
	int results_seen  = 0;

	// long hold-off, armed by the sequencer, run by the receiver
	logic pressure_armed = 1'b0;
	int   pressure_at    = 0;
	logic hold_done      = 1'b0;
	int   hold_count     = 0;

	// Advance the shadow by one accepted tick and return its result beat.
	task automatic advance_controller(input tick_item_t t, output tick_result_t r);
		evt_code_t   ev;
		logic [32:0] sum;
		ev = EV_NONE;

		// both timers count first, saturating at the counter width
		if (shadow_since_poll != CNT_MAX)
			shadow_since_poll = shadow_since_poll + 1'b1;
		if (shadow_since_alarm != CNT_MAX)
			shadow_since_alarm = shadow_since_alarm + 1'b1;

		sum = {1'b0, shadow_total} + 33'(t.flow);
		shadow_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

		// close takes the tick's event slot: no poll, rotation holds
		if (t.close) begin
			ev = EV_CLOSE;
		end else if (shadow_since_poll > {1'b0, shadow_cfg.poll_ivl}) begin
			shadow_since_poll = '0;
			case (shadow_det)
				DET_BUTTON: begin
					if (t.push)
						ev = EV_BUTTON;
				end
				// band and limit flags latch even if the mode machine ignores the event
				DET_BAND1: begin
					if (shadow_mode <= MC_OPEN && !shadow_used[0] &&
						shadow_total >= shadow_cfg.band_one &&
						shadow_total < shadow_cfg.band_two) begin
						shadow_used = shadow_used | 4'b0001;
						ev = EV_BAND1;
					end
				end
				DET_BAND2: begin
					if (shadow_mode <= MC_ALARM1 && !shadow_used[1] &&
						shadow_total >= shadow_cfg.band_two &&
						shadow_total < shadow_cfg.band_three) begin
						shadow_used = shadow_used | 4'b0011;
						ev = EV_BAND2;
					end
				end
				DET_BAND3: begin
					if (shadow_mode <= MC_ALARM2 && !shadow_used[2] &&
						shadow_total >= shadow_cfg.band_three &&
						shadow_total < shadow_cfg.limit) begin
						shadow_used = shadow_used | 4'b0111;
						ev = EV_BAND3;
					end
				end
				DET_LIMIT: begin
					if (shadow_mode <= MC_ALARM3 && !shadow_used[3] &&
						shadow_total >= shadow_cfg.limit) begin
						shadow_used = 4'b1111;
						ev = EV_LIMIT;
					end
				end
				DET_TIMEOUT: begin
					if (shadow_mode >= MC_ALARM1 && shadow_mode <= MC_LIMIT &&
						shadow_since_alarm > {1'b0, shadow_cfg.alarm_hold})
						ev = EV_TIMEOUT;
				end
				default: ;
			endcase
			shadow_det = (shadow_det == DET_LAST) ? DET_BUTTON : shadow_det + 1'b1;
		end

		// mode machine
		case (shadow_mode)
			MC_IDLE: begin
				if (ev == EV_BUTTON) begin
					shadow_valve = 1'b1;
					shadow_mode = MC_OPEN;
				end
			end
			MC_OPEN: begin
				// entry from open restarts the alarm timer
				if (ev == EV_BUTTON || ev == EV_CLOSE) begin
					shadow_valve = 1'b0;
					shadow_mode = MC_IDLE;
				end else if (ev == EV_BAND1) begin
					shadow_mode = MC_ALARM1;
					shadow_buzz = BUZZ_BAND1;
					shadow_since_alarm = '0;
				end else if (ev == EV_BAND2) begin
					shadow_mode = MC_ALARM2;
					shadow_buzz = BUZZ_BAND2;
					shadow_since_alarm = '0;
				end else if (ev == EV_BAND3) begin
					shadow_mode = MC_ALARM3;
					shadow_buzz = BUZZ_BAND3;
					shadow_since_alarm = '0;
				end else if (ev == EV_LIMIT) begin
					shadow_mode = MC_LIMIT;
					shadow_buzz = BUZZ_LIMIT;
					shadow_since_alarm = '0;
				end
			end
			MC_ALARM1, MC_ALARM2, MC_ALARM3: begin
				// escalation keeps the timer running; close leaves the buzzer alone
				if (ev == EV_TIMEOUT) begin
					shadow_buzz = BUZZ_OFF;
					shadow_mode = MC_OPEN;
				end else if (ev == EV_CLOSE) begin
					shadow_valve = 1'b0;
					shadow_mode = MC_IDLE;
				end else if (shadow_mode == MC_ALARM1 && ev == EV_BAND2) begin
					shadow_mode = MC_ALARM2;
					shadow_buzz = BUZZ_BAND2;
				end else if (shadow_mode == MC_ALARM2 && ev == EV_BAND3) begin
					shadow_mode = MC_ALARM3;
					shadow_buzz = BUZZ_BAND3;
				end else if (shadow_mode == MC_ALARM3 && ev == EV_LIMIT) begin
					shadow_mode = MC_LIMIT;
					shadow_buzz = BUZZ_LIMIT;
				end
			end
			MC_LIMIT: begin
				if (ev == EV_TIMEOUT) begin
					shadow_buzz = BUZZ_OFF;
					shadow_valve = 1'b0;
					shadow_mode = MC_FINISHED;
				end
			end
			MC_FINISHED: begin
				// reset of the total also drops this tick's flow
				if (ev == EV_BUTTON) begin
					shadow_total = '0;
					shadow_used = '0;
					shadow_mode = MC_IDLE;
				end
			end
			default: ;
		endcase

		r.evt   = ev;
		r.mode  = shadow_mode;
		r.valve = shadow_valve;
		r.buzz  = shadow_buzz;
		r.total = shadow_total;
	endtask

	// ---------------------------------------------------------------
	// Driver: one beat per accepted tick; the held payload is predicted
	// at the edge it is taken. Valid only drops after a beat.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : tick_driver
		tick_result_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				advance_controller(offered, res);
				predicted_outputs.push_back(res);
			end
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered = pending_ticks.pop_front();
				in_valid      <= 1'b1;
				button_push   <= offered.push;
				flow_ml       <= offered.flow;
				close_request <= offered.close;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall, plus one long hold-off once armed.
	always @(posedge clk) begin : result_receiver
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (pressure_armed && !hold_done && results_seen >= pressure_at) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: each result beat against the oldest prediction.
	always @(posedge clk) begin : result_checker
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (predicted_outputs.size() == 0) begin
				$error("result beat with no prediction waiting");
				fail_count++;
			end else begin
				want = predicted_outputs.pop_front();
				if (event_code !== want.evt) begin
					$error("event_code: expected %0d, got %0d", want.evt, event_code);
					fail_count++;
				end
				if (mode !== want.mode) begin
					$error("mode: expected %0d, got %0d", want.mode, mode);
					fail_count++;
				end
				if (valve_on !== want.valve) begin
					$error("valve_on: expected %0d, got %0d", want.valve, valve_on);
					fail_count++;
				end
				if (buzzer_level !== want.buzz) begin
					$error("buzzer_level: expected %0d, got %0d", want.buzz, buzzer_level);
					fail_count++;
				end
				if (total_out_ml !== want.total) begin
					$error("total_out_ml: expected %0d, got %0d", want.total, total_out_ml);
					fail_count++;
				end
			end
		end
	end

	// Register write; the shadow copy follows at once since the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BAND_ONE:   shadow_cfg.band_one   = data;
			REG_BAND_TWO:   shadow_cfg.band_two   = data;
			REG_BAND_THREE: shadow_cfg.band_three = data;
			REG_LIMIT:      shadow_cfg.limit      = data;
			REG_POLL_IVL:   shadow_cfg.poll_ivl   = data[TICKS_W-1:0];
			REG_ALARM_HOLD: shadow_cfg.alarm_hold = data[TICKS_W-1:0];
			default: ;
		endcase
	endtask

	// 16-bit registers get junk in the upper half, which must be dropped
	function automatic logic [CFG_DATA_W-1:0] ticks_word(input logic [TICKS_W-1:0] v);
		return {16'($urandom), v};
	endfunction

	task automatic queue_tick(input logic push, input logic [FLOW_W-1:0] flow,
		input logic close);
		pending_ticks.push_back('{push: push, flow: flow, close: close});
	endtask

	// Mostly trickle flow so bands get hit in order; a few bursts and extremes.
	task automatic queue_random_ticks(input int count);
		tick_item_t it;
		int r;
		for (int i = 0; i < count; i++) begin
			it.push  = ($urandom_range(99) < 35);
			it.close = ($urandom_range(99) < 4);
			r = $urandom_range(99);
			if (r < 90)
				it.flow = FLOW_W'($urandom_range(12));
			else if (r < 95)
				it.flow = FLOW_W'($urandom_range(1023));
			else if (r < 97)
				it.flow = FLOW_MAX;
			else
				it.flow = '0;
			pending_ticks.push_back(it);
		end
	endtask

	// Wait until every tick is taken and every result checked, then let
	// the pipeline go quiet.
	task automatic drain_and_settle();
		@(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || predicted_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Sequencer: phases of register settings and tick streams.
	// ---------------------------------------------------------------
	initial begin : sequencer
		logic [TOTAL_W-1:0] b1;
		logic [TOTAL_W-1:0] b2;
		logic [TOTAL_W-1:0] b3;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: tiny bands, poll every tick, one-tick alarm hold
		send_idle_pct = 8;
		stall_pct = 51;
		write_reg(REG_BAND_ONE, 32'd4);
		write_reg(REG_BAND_TWO, 32'd8);
		write_reg(REG_BAND_THREE, 32'd12);
		write_reg(REG_LIMIT, 32'd16);
		write_reg(REG_POLL_IVL, ticks_word(16'd0));
		write_reg(REG_ALARM_HOLD, ticks_word(16'd1));

		queue_tick(1'b1, 10'd0, 1'b0);     // button -> open
		queue_tick(1'b0, 10'd5, 1'b0);     // band one -> alarm1
		queue_tick(1'b0, 10'd4, 1'b0);     // escalate to alarm2, timer keeps running
		queue_tick(1'b0, 10'd4, 1'b0);     // alarm3
		queue_tick(1'b0, 10'd4, 1'b0);     // limit
		queue_tick(1'b0, 10'd0, 1'b0);     // timeout -> finished, valve off
		queue_tick(1'b1, FLOW_MAX, 1'b0);  // button in finished: total cleared, flow lost
		queue_tick(1'b1, 10'd0, 1'b0);     // push while band one is polled: ignored
		queue_tick(1'b0, 10'd0, 1'b1);     // close in idle, rotation holds
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b1, 10'd0, 1'b0);     // open
		queue_tick(1'b1, 10'd0, 1'b1);     // close wins over push
		queue_tick(1'b0, 10'd6, 1'b0);     // band one fires in idle: flag set, no move
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b1, 10'd0, 1'b0);     // open
		queue_tick(1'b0, 10'd0, 1'b0);     // band one already used
		queue_tick(1'b0, FLOW_MAX, 1'b0);  // past band three
		queue_tick(1'b0, 10'd0, 1'b0);
		queue_tick(1'b0, 10'd0, 1'b0);     // limit straight from open
		queue_tick(1'b0, 10'd0, 1'b1);     // close has no effect in limit
		drain_and_settle();

		// random, poll every tick
		write_reg(REG_BAND_ONE, 32'd200);
		write_reg(REG_BAND_TWO, 32'd400);
		write_reg(REG_BAND_THREE, 32'd600);
		write_reg(REG_LIMIT, 32'd800);
		write_reg(REG_ALARM_HOLD, ticks_word(16'd10));
		queue_random_ticks(280);
		drain_and_settle();

		// all registers at maximum; out-of-range writes must be dropped
		write_reg(REG_BAND_ONE, TOTAL_MAX);
		write_reg(REG_BAND_TWO, TOTAL_MAX);
		write_reg(REG_BAND_THREE, TOTAL_MAX);
		write_reg(REG_LIMIT, TOTAL_MAX);
		write_reg(REG_POLL_IVL, ticks_word(16'hFFFF));
		write_reg(REG_ALARM_HOLD, ticks_word(16'hFFFF));
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		queue_random_ticks(20);
		drain_and_settle();

		// sender idles more than the receiver stalls
		send_idle_pct = 51;
		stall_pct = 8;
		write_reg(REG_BAND_ONE, 32'd300);
		write_reg(REG_BAND_TWO, 32'd700);
		write_reg(REG_BAND_THREE, 32'd1100);
		write_reg(REG_LIMIT, 32'd1500);
		write_reg(REG_POLL_IVL, ticks_word(16'd1));
		write_reg(REG_ALARM_HOLD, ticks_word(16'd0));
		queue_random_ticks(280);
		drain_and_settle();

		// all registers at zero: limit matches at any total
		write_reg(REG_BAND_ONE, '0);
		write_reg(REG_BAND_TWO, '0);
		write_reg(REG_BAND_THREE, '0);
		write_reg(REG_LIMIT, '0);
		write_reg(REG_POLL_IVL, ticks_word(16'd0));
		write_reg(REG_ALARM_HOLD, ticks_word(16'd0));
		queue_random_ticks(60);
		drain_and_settle();

		// no idling, random bands, and one long hold-off mid-stream
		send_idle_pct = 0;
		stall_pct = 0;
		b1 = $urandom_range(400, 50);
		b2 = b1 + $urandom_range(500, 100);
		b3 = b2 + $urandom_range(500, 100);
		write_reg(REG_BAND_ONE, b1);
		write_reg(REG_BAND_TWO, b2);
		write_reg(REG_BAND_THREE, b3);
		write_reg(REG_LIMIT, b3 + $urandom_range(500, 100));
		write_reg(REG_POLL_IVL, ticks_word(16'd2));
		write_reg(REG_ALARM_HOLD, ticks_word(16'($urandom_range(20))));
		pressure_at = results_seen + 60;
		pressure_armed = 1'b1;
		queue_random_ticks(280);
		drain_and_settle();

		if (fail_count == 0 && predicted_outputs.size() == 0) begin
			$display("staged_consumption_valve_controller regression: pass");
		end else begin
			$display("staged_consumption_valve_controller regression: fail");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("staged_consumption_valve_controller regression: fail");
		$finish;
	end

endmodule
